### hdl/rcm_pkg.sv
// Shared types and constants for the reverse Cuthill-McKee ordering unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package rcm_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int DEGREE_BITS  = 11;
  localparam logic [DEGREE_BITS-1:0] DEGREE_MAX = {DEGREE_BITS{1'b1}};

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_WR, ST_SS_RD, ST_SS_CMP, ST_TAKE,
    ST_DQ, ST_DQ_ROW, ST_EMIT, ST_NB, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic ld_rd;
    logic ld_wr;
    logic run_init;
    logic ss_init;
    logic ss_rd;
    logic ss_cmp;
    logic ss_take;
    logic dq_rd;
    logic row_rd;
    logic emit;
    logic nb_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic scan_end;
    logic best_found;
    logic q_empty;
    logic c_end;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

### hdl/rcm_ctrl.sv
// Controller state machine for the ordering unit.
// Depends on rcm_pkg; drives datapath commands from datapath status.
`default_nettype none
module rcm_ctrl import rcm_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  input  wire   req_type,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);
  state_t state, state_next;

  // hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // pick next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_RUN) begin
            cmd.run_init = 1'b1;
            cmd.ss_init  = 1'b1;
            state_next   = ST_SS_RD;
          end else if (stat.edge_ok) begin
            cmd.ld_rd  = 1'b1;
            state_next = ST_LD_WR;
          end
        end
      end
      ST_LD_WR: begin
        cmd.ld_wr  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SS_RD: begin
        if (stat.scan_end) begin
          state_next = stat.best_found ? ST_TAKE : ST_CLEAR;
        end else begin
          cmd.ss_rd  = 1'b1;
          state_next = ST_SS_CMP;
        end
      end
      ST_SS_CMP: begin
        cmd.ss_cmp = 1'b1;
        state_next = ST_SS_RD;
      end
      ST_TAKE: begin
        cmd.ss_take = 1'b1;
        state_next  = ST_DQ;
      end
      ST_DQ: begin
        if (stat.q_empty) begin
          cmd.ss_init = 1'b1;
          state_next  = ST_SS_RD;
        end else begin
          cmd.dq_rd  = 1'b1;
          state_next = ST_DQ_ROW;
        end
      end
      ST_DQ_ROW: begin
        cmd.row_rd = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_NB;
        end
      end
      ST_NB: begin
        if (stat.c_end) state_next = ST_DQ;
        else            cmd.nb_step = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/rcm_datapath.sv
// Datapath: adjacency, degree and walk queue memories, visit state, output register.
// Depends on rcm_pkg; steered by rcm_ctrl through cmd_t and stat_t.
`default_nettype none
module rcm_datapath import rcm_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [CNT_W-1:0]  cfg_wdata,
  input  wire [IDX_W-1:0]  edge_row,
  input  wire [IDX_W-1:0]  edge_col,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  wire              out_ready,
  output logic             out_valid,
  output logic [IDX_W-1:0] position,
  output logic [IDX_W-1:0] vertex,
  output logic             last_of_order
);
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [DEGREE_BITS-1:0]  deg_mem [MAX_VERTICES];
  logic [IDX_W-1:0]        q_mem   [MAX_VERTICES];

  logic [CNT_W-1:0]        vertex_count;
  logic [CNT_W-1:0]        n_eff;
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] row_bits;
  logic [MAX_VERTICES-1:0] adj_rd;
  logic [DEGREE_BITS-1:0]  deg_rd;
  logic [IDX_W-1:0]        q_rd;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        rd_last;
  logic                    rd_en;
  logic [IDX_W-1:0]        ld_row, ld_col;
  logic [CNT_W-1:0]        scan_v;
  logic [CNT_W-1:0]        nb_c;
  logic                    best_found;
  logic [DEGREE_BITS-1:0]  best_deg;
  logic [IDX_W-1:0]        best_v;
  logic [CNT_W-1:0]        head, tail;
  logic [CNT_W-1:0]        wpos;
  logic [DEGREE_BITS-1:0]  deg_eff;
  logic [MAX_VERTICES-1:0] adj_eff;
  logic                    q_we;
  logic [IDX_W-1:0]        q_wdata;
  logic                    nb_hit;

  assign n_eff = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;

  // hold the vertex count register
  always_ff @(posedge clk) begin
    if (rst)         vertex_count <= CNT_W'(MAX_VERTICES);
    else if (cfg_we) vertex_count <= cfg_wdata;
  end

  // steer the shared read address of the adjacency and degree stores
  always_comb begin
    rd_addr = scan_v[IDX_W-1:0];
    if (cmd.ld_rd)       rd_addr = edge_row;
    else if (cmd.row_rd) rd_addr = q_rd;
    rd_en = cmd.ld_rd | cmd.ss_rd | cmd.row_rd;
  end

  // read and write the adjacency and degree stores
  always_ff @(posedge clk) begin
    if (rd_en) begin
      adj_rd <= adj_mem[rd_addr];
      deg_rd <= deg_mem[rd_addr];
    end
    if (cmd.ld_wr) begin
      adj_mem[ld_row] <= adj_eff | (MAX_VERTICES'(1) << ld_col);
      deg_mem[ld_row] <= (deg_eff == DEGREE_MAX) ? deg_eff : deg_eff + 1'b1;
    end
  end

  // treat rows never loaded since the last clear as empty
  always_comb begin
    adj_eff = row_valid[rd_last] ? adj_rd : '0;
    deg_eff = row_valid[rd_last] ? deg_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_last <= rd_addr;
  end

  // track which rows hold data; drop all of them after a run
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) row_valid <= '0;
    else if (cmd.ld_wr)   row_valid[ld_row] <= 1'b1;
  end

  // latch the edge of a load transaction
  always_ff @(posedge clk) begin
    if (cmd.ld_rd) begin
      ld_row <= edge_row;
      ld_col <= edge_col;
    end
  end

  // scan for the lowest-degree unvisited start vertex
  always_ff @(posedge clk) begin
    if (rst || cmd.ss_init) begin
      scan_v     <= '0;
      best_found <= 1'b0;
    end else if (cmd.ss_cmp) begin
      if (!visited[scan_v[IDX_W-1:0]] && (!best_found || deg_eff < best_deg)) begin
        best_found <= 1'b1;
        best_deg   <= deg_eff;
        best_v     <= scan_v[IDX_W-1:0];
      end
      scan_v <= scan_v + 1'b1;
    end
  end

  // walk queue write and read ports
  assign nb_hit  = cmd.nb_step && row_bits[nb_c[IDX_W-1:0]] && !visited[nb_c[IDX_W-1:0]];
  assign q_we    = cmd.ss_take | nb_hit;
  assign q_wdata = cmd.ss_take ? best_v : nb_c[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (q_we)      q_mem[tail[IDX_W-1:0]] <= q_wdata;
    if (cmd.dq_rd) q_rd <= q_mem[head[IDX_W-1:0]];
  end

  // advance queue pointers, visit marks and the write position;
  // each walk continues in the queue where the last one drained
  always_ff @(posedge clk) begin
    if (rst || cmd.run_init) begin
      head    <= '0;
      tail    <= '0;
      visited <= '0;
      wpos    <= cmd.run_init ? n_eff : '0;
    end else begin
      if (cmd.ss_take) begin
        tail <= tail + 1'b1;
        visited[best_v] <= 1'b1;
      end else if (nb_hit) begin
        tail <= tail + 1'b1;
        visited[nb_c[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.dq_rd) head <= head + 1'b1;
      if (cmd.emit)  wpos <= wpos - 1'b1;
    end
  end

  // hold the row under neighbor scan and step its column counter
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_bits <= adj_eff;
      nb_c     <= '0;
    end else if (cmd.nb_step) begin
      nb_c <= nb_c + 1'b1;
    end
  end

  // output register; a new result may load as the old one is taken
  always_ff @(posedge clk) begin
    if (rst)                        out_valid <= 1'b0;
    else if (cmd.emit)              out_valid <= 1'b1;
    else if (out_valid && out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      position      <= IDX_W'(wpos - 1'b1);
      vertex        <= q_rd;
      last_of_order <= (wpos == CNT_W'(1));
    end
  end

  // report status to the controller
  always_comb begin
    stat.edge_ok    = (CNT_W'(edge_row) < n_eff) && (CNT_W'(edge_col) < n_eff);
    stat.scan_end   = (scan_v >= n_eff);
    stat.best_found = best_found;
    stat.q_empty    = (head == tail);
    stat.c_end      = (nb_c >= n_eff);
    stat.out_busy   = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

### hdl/reverse_cuthill_mckee_order_unit.sv
// Top level of the reverse Cuthill-McKee ordering unit.
// Depends on rcm_pkg, rcm_ctrl and rcm_datapath.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, edge_row, edge_col
//   out      output     out_valid / out_ready position, vertex, last_of_order
//   cfg      input      cfg_we                cfg_wdata (vertex_count)
//
// An in-range edge load reads then writes its row; an ignored edge is
// dropped. A run scans the degree store for each start vertex, then
// scans the neighbor bits of each vertex it takes from the walk queue.
// Reset is synchronous; the stores read as empty right after it, no pass.
// A stalled output holds the walk at the next emit; input is taken only idle.
`default_nettype none
module reverse_cuthill_mckee_order_unit import rcm_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [CNT_W-1:0]  cfg_wdata,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              req_type,
  input  wire [IDX_W-1:0]  edge_row,
  input  wire [IDX_W-1:0]  edge_col,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [IDX_W-1:0] position,
  output logic [IDX_W-1:0] vertex,
  output logic             last_of_order
);
  cmd_t  cmd;
  stat_t stat;

  rcm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .req_type(req_type),
    .stat(stat), .in_ready(in_ready), .cmd(cmd)
  );

  rcm_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .edge_row(edge_row), .edge_col(edge_col), .cmd(cmd), .stat(stat),
    .out_ready(out_ready), .out_valid(out_valid), .position(position),
    .vertex(vertex), .last_of_order(last_of_order)
  );
endmodule
`default_nettype wire

### hdl/rcm_checker.sv
// Port-level assertions for the ordering unit, bound to the top level.
// Depends on rcm_pkg and reverse_cuthill_mckee_order_unit.
`default_nettype none
module rcm_checker import rcm_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire [IDX_W-1:0] position,
  input wire [IDX_W-1:0] vertex,
  input wire             last_of_order
);
  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(position) && $stable(vertex))
    else $error("result changed while stalled");

  // the last flag marks exactly slot zero
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_order == (position == '0)))
    else $error("last flag off slot zero");

  // leave reset idle and empty
  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("not idle after reset");
endmodule

bind reverse_cuthill_mckee_order_unit rcm_checker u_rcm_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .position(position), .vertex(vertex),
  .last_of_order(last_of_order)
);
`default_nettype wire

### tb/sv/reverse_cuthill_mckee_order_unit_test.sv
// Self-checking testbench for the reverse Cuthill-McKee ordering unit.
// Depends on rcm_pkg and reverse_cuthill_mckee_order_unit; runs standalone.
module reverse_cuthill_mckee_order_unit_test;
  import rcm_pkg::*;

  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] vertex;
    logic             last_of_order;
  } slot_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             req_type = REQ_LOAD;
  logic [IDX_W-1:0] edge_row = '0;
  logic [IDX_W-1:0] edge_col = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] position;
  logic [IDX_W-1:0] vertex;
  logic             last_of_order;

  // Shadow copy of the block state
  logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
  int                      row_degree [MAX_VERTICES];
  logic [CNT_W-1:0]        vcount_shadow = 7'd64;

  slot_t pending_slots [$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_off_cycles = 0;
  int    items_sent = 0;

  reverse_cuthill_mckee_order_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .edge_row(edge_row), .edge_col(edge_col),
    .out_valid(out_valid), .out_ready(out_ready), .position(position),
    .vertex(vertex), .last_of_order(last_of_order)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the receiver at random, or for a long counted stretch
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready = 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expected slot
  always @(posedge clk) begin
    slot_t exp_slot;
    if (!rst && out_valid && out_ready) begin
      if (pending_slots.size() == 0) begin
        $error("unexpected result: position %0d vertex %0d", position, vertex);
        errors++;
      end else begin
        exp_slot = pending_slots.pop_front();
        if (position !== exp_slot.position) begin
          $error("position: expected %0d, got %0d", exp_slot.position, position);
          errors++;
        end
        if (vertex !== exp_slot.vertex) begin
          $error("vertex: expected %0d, got %0d", exp_slot.vertex, vertex);
          errors++;
        end
        if (last_of_order !== exp_slot.last_of_order) begin
          $error("last_of_order: expected %0d, got %0d", exp_slot.last_of_order,
                 last_of_order);
          errors++;
        end
      end
    end
  end

  function automatic int active_vertices();
    return (vcount_shadow > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_shadow);
  endfunction

  // Work out the slots one accepted transaction produces
  task automatic predict_item(logic req, int row, int col);
    int n;
    int start_list [$];
    int walk [$];
    logic [MAX_VERTICES-1:0] taken;
    logic [MAX_VERTICES-1:0] seen;
    int best;
    int wpos;
    int x;
    slot_t s;
    n = active_vertices();
    if (req == REQ_LOAD) begin
      if (row < n && col < n) begin
        adj_rows[row][col] = 1'b1;
        if (row_degree[row] < int'(DEGREE_MAX)) row_degree[row]++;
      end
    end else begin
      // order starts by degree, lower index on ties
      taken = '0;
      for (int k = 0; k < n; k++) begin
        best = -1;
        for (int v = 0; v < n; v++)
          if (!taken[v] && (best < 0 || row_degree[v] < row_degree[best])) best = v;
        taken[best] = 1'b1;
        start_list.push_back(best);
      end
      seen = '0;
      wpos = n;
      foreach (start_list[i]) begin
        if (seen[start_list[i]]) continue;
        walk.delete();
        walk.push_back(start_list[i]);
        seen[start_list[i]] = 1'b1;
        while (walk.size() > 0) begin
          x = walk.pop_front();
          wpos--;
          s.position = wpos[IDX_W-1:0];
          s.vertex = x[IDX_W-1:0];
          s.last_of_order = (wpos == 0);
          pending_slots.push_back(s);
          for (int c = 0; c < n; c++)
            if (adj_rows[x][c] && !seen[c]) begin
              seen[c] = 1'b1;
              walk.push_back(c);
            end
        end
      end
      for (int v = 0; v < MAX_VERTICES; v++) begin
        adj_rows[v] = '0;
        row_degree[v] = 0;
      end
    end
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic req, int row, int col);
    if ($urandom_range(99) < send_idle_pct) repeat ($urandom_range(4, 1)) @(negedge clk);
    in_valid = 1'b1;
    req_type = req;
    edge_row = row[IDX_W-1:0];
    edge_col = col[IDX_W-1:0];
    do @(posedge clk); while (!in_ready);
    predict_item(req, row, col);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drain outstanding slots, let the block settle, then write vertex_count
  task automatic set_vertex_count(int value);
    while (pending_slots.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value[CNT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    vcount_shadow = value[CNT_W-1:0];
  endtask

  task automatic test_reset_count();
    send_item(REQ_LOAD, 63, 63);
    send_item(REQ_LOAD, 0, 63);
    send_item(REQ_LOAD, 63, 0);
    send_item(REQ_LOAD, 0, 63);
    send_item(REQ_LOAD, 21, 42);
    send_item(REQ_RUN, 63, 63);
  endtask

  task automatic test_out_of_range();
    set_vertex_count(5);
    send_item(REQ_LOAD, 4, 3);
    send_item(REQ_LOAD, 5, 1);
    send_item(REQ_LOAD, 1, 5);
    send_item(REQ_LOAD, 63, 0);
    send_item(REQ_LOAD, 2, 63);
    send_item(REQ_LOAD, 3, 3);
    send_item(REQ_RUN, 42, 21);
  endtask

  task automatic test_count_extremes();
    set_vertex_count(0);
    send_item(REQ_LOAD, 0, 0);
    send_item(REQ_RUN, 0, 0);
    set_vertex_count(1);
    send_item(REQ_LOAD, 0, 0);
    send_item(REQ_RUN, 0, 0);
    set_vertex_count(127);
    send_item(REQ_LOAD, 10, 11);
    send_item(REQ_LOAD, 11, 12);
    send_item(REQ_RUN, 0, 0);
  endtask

  // Repeat one edge so its row outranks the others in degree
  task automatic test_duplicate_edges();
    set_vertex_count(4);
    repeat (12) send_item(REQ_LOAD, 0, 1);
    send_item(REQ_LOAD, 3, 2);
    send_item(REQ_LOAD, 2, 0);
    send_item(REQ_RUN, 0, 0);
  endtask

  task automatic send_random_graph(int n, int edges);
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(99) < 85)
        send_item(REQ_LOAD, $urandom_range(n - 1), $urandom_range(n - 1));
      else
        send_item(REQ_LOAD, $urandom_range(63), $urandom_range(63));
    end
    send_item(REQ_RUN, $urandom_range(63), $urandom_range(63));
  endtask

  // Stall the output long enough that the block refuses further input
  task automatic test_output_backpressure();
    set_vertex_count(16);
    send_random_graph(16, 20);
    hold_off_cycles = 3000;
    send_random_graph(16, 10);
    send_item(REQ_RUN, 0, 0);
  endtask

  task automatic test_random_orders();
    int n;
    int base;
    base = items_sent;
    while (items_sent - base < 200) begin
      if (items_sent - base < 65) begin
        send_idle_pct = 6;
        recv_idle_pct = 60;
      end else if (items_sent - base < 130) begin
        send_idle_pct = 60;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0:       n = $urandom_range(64, 127);
        1:       n = $urandom_range(17, 64);
        default: n = $urandom_range(2, 16);
      endcase
      set_vertex_count(n);
      send_random_graph((n > MAX_VERTICES) ? MAX_VERTICES : n, $urandom_range(24));
    end
  endtask

  initial begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      adj_rows[v] = '0;
      row_degree[v] = 0;
    end
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_reset_count();
    test_out_of_range();
    test_count_extremes();
    test_duplicate_edges();
    test_output_backpressure();
    test_random_orders();
    while (pending_slots.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_slots.size() == 0)
      $display("reverse_cuthill_mckee_order_unit verification clean");
    else
      $display("reverse_cuthill_mckee_order_unit verification failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("reverse_cuthill_mckee_order_unit verification failed");
    $finish;
  end
endmodule
